/* design/c6502_pkg.sv */
// c6502_pkg: opcode decode table, phase codes and constants for the 6502 load/store core
// used by cpu6502_load_store_core and its testbench; no dependencies
`default_nettype none
package c6502_pkg;

  localparam logic [15:0] VecReset  = 16'hFFFC;
  localparam logic [15:0] VecIrq    = 16'hFFFE;
  localparam logic [15:0] VecNmi    = 16'hFFFA;
  localparam logic [7:0]  StackHi   = 8'h01;
  localparam logic [7:0]  SpReset   = 8'hFD;
  localparam logic [7:0]  FlagN     = 8'h80;
  localparam logic [7:0]  FlagU     = 8'h20;
  localparam logic [7:0]  FlagB     = 8'h10;
  localparam logic [7:0]  FlagI     = 8'h04;
  localparam logic [7:0]  FlagZ     = 8'h02;

  typedef enum logic [1:0] {
    KIND_DONE = 2'd0,
    KIND_IRQ  = 2'd1,
    KIND_NMI  = 2'd2,
    KIND_RST  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    M_IMP, M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABX, M_ABY, M_IDX, M_IDY, M_STK
  } mode_e;

  typedef enum logic [3:0] {
    O_LDA, O_LDX, O_LDY, O_STA, O_STX, O_STY, O_TAX, O_TAY, O_TXA, O_TYA,
    O_TSX, O_TXS, O_PHA, O_PHP, O_PLA, O_PLP
  } oper_e;

  typedef enum logic [3:0] {
    P_RST_LO, P_RST_HI, P_FETCH, P_OPER, P_ABS_HI, P_PTR_LO, P_PTR_HI, P_DATA,
    P_INT_PCH, P_INT_PCL, P_INT_P, P_INT_VLO, P_INT_VHI
  } phase_e;

  typedef struct packed {
    logic       valid;
    mode_e      mode;
    oper_e      oper;
    logic [3:0] cyc;
  } op_entry_t;

  function automatic op_entry_t decode(input logic [7:0] op);
    op_entry_t e;
    e = '{valid: 1'b1, mode: M_IMP, oper: O_LDA, cyc: 4'd2};
    unique case (op)
      8'hA9: e = '{1'b1, M_IMM, O_LDA, 4'd2};
      8'hA5: e = '{1'b1, M_ZP,  O_LDA, 4'd3};
      8'hB5: e = '{1'b1, M_ZPX, O_LDA, 4'd4};
      8'hAD: e = '{1'b1, M_ABS, O_LDA, 4'd4};
      8'hBD: e = '{1'b1, M_ABX, O_LDA, 4'd4};
      8'hB9: e = '{1'b1, M_ABY, O_LDA, 4'd4};
      8'hA1: e = '{1'b1, M_IDX, O_LDA, 4'd6};
      8'hB1: e = '{1'b1, M_IDY, O_LDA, 4'd5};
      8'hA2: e = '{1'b1, M_IMM, O_LDX, 4'd2};
      8'hA6: e = '{1'b1, M_ZP,  O_LDX, 4'd3};
      8'hB6: e = '{1'b1, M_ZPY, O_LDX, 4'd4};
      8'hAE: e = '{1'b1, M_ABS, O_LDX, 4'd4};
      8'hBE: e = '{1'b1, M_ABY, O_LDX, 4'd4};
      8'hA0: e = '{1'b1, M_IMM, O_LDY, 4'd2};
      8'hA4: e = '{1'b1, M_ZP,  O_LDY, 4'd3};
      8'hB4: e = '{1'b1, M_ZPX, O_LDY, 4'd4};
      8'hAC: e = '{1'b1, M_ABS, O_LDY, 4'd4};
      8'hBC: e = '{1'b1, M_ABX, O_LDY, 4'd4};
      8'h85: e = '{1'b1, M_ZP,  O_STA, 4'd3};
      8'h95: e = '{1'b1, M_ZPX, O_STA, 4'd4};
      8'h8D: e = '{1'b1, M_ABS, O_STA, 4'd4};
      8'h9D: e = '{1'b1, M_ABX, O_STA, 4'd5};
      8'h99: e = '{1'b1, M_ABY, O_STA, 4'd5};
      8'h81: e = '{1'b1, M_IDX, O_STA, 4'd6};
      8'h91: e = '{1'b1, M_IDY, O_STA, 4'd6};
      8'h86: e = '{1'b1, M_ZP,  O_STX, 4'd3};
      8'h96: e = '{1'b1, M_ZPY, O_STX, 4'd4};
      8'h8E: e = '{1'b1, M_ABS, O_STX, 4'd4};
      8'h84: e = '{1'b1, M_ZP,  O_STY, 4'd3};
      8'h94: e = '{1'b1, M_ZPX, O_STY, 4'd4};
      8'h8C: e = '{1'b1, M_ABS, O_STY, 4'd4};
      8'hAA: e = '{1'b1, M_IMP, O_TAX, 4'd2};
      8'hA8: e = '{1'b1, M_IMP, O_TAY, 4'd2};
      8'h8A: e = '{1'b1, M_IMP, O_TXA, 4'd2};
      8'h98: e = '{1'b1, M_IMP, O_TYA, 4'd2};
      8'hBA: e = '{1'b1, M_IMP, O_TSX, 4'd2};
      8'h9A: e = '{1'b1, M_IMP, O_TXS, 4'd2};
      8'h48: e = '{1'b1, M_STK, O_PHA, 4'd3};
      8'h08: e = '{1'b1, M_STK, O_PHP, 4'd3};
      8'h68: e = '{1'b1, M_STK, O_PLA, 4'd4};
      8'h28: e = '{1'b1, M_STK, O_PLP, 4'd4};
      default: e.valid = 1'b0;
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

/* design/c6502_if.sv */
// c6502_in_if / c6502_out_if: valid/ready channels of the core
// depends on nothing outside this file
`default_nettype none
interface c6502_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] read_data;
  modport source (output valid, output kind, output read_data, input ready);
  modport sink   (input valid, input kind, input read_data, output ready);
endinterface

interface c6502_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] bus_address;
  logic        bus_write;
  logic [7:0]  write_data;
  logic        at_boundary;
  logic [3:0]  cycle_count;
  logic        illegal_opcode;
  logic [7:0]  reg_a;
  logic [7:0]  reg_x;
  logic [7:0]  reg_y;
  logic [7:0]  reg_sp;
  logic [7:0]  reg_status;
  logic [15:0] reg_pc;
  modport source (output valid, output bus_address, output bus_write, output write_data,
                  output at_boundary, output cycle_count, output illegal_opcode,
                  output reg_a, output reg_x, output reg_y, output reg_sp,
                  output reg_status, output reg_pc, input ready);
  modport sink   (input valid, input bus_address, input bus_write, input write_data,
                  input at_boundary, input cycle_count, input illegal_opcode,
                  input reg_a, input reg_x, input reg_y, input reg_sp,
                  input reg_status, input reg_pc, output ready);
endinterface
`default_nettype wire

/* design/cpu6502_load_store_core.sv */
// cpu6502_load_store_core: bus-stepped 6502 subset (loads, stores, transfers, stack, interrupts)
// depends on c6502_pkg and the channel interfaces in c6502_if.sv
//
// Each input beat reports that the pending bus access has finished (with its read byte) or
// carries an irq, nmi or reset request; it yields exactly one output beat naming the next
// access, with the register file and, at an instruction boundary, the cycles charged. One beat
// is taken per clock: the next state and result are worked out in one pass of the decoder and
// the 8/16-bit address adders and land in the architectural registers and the output register
// together. The output register holds a result while the sink stalls, and a new beat is taken
// in the same cycle as the held one leaves, so throughput is one beat per cycle.
`default_nettype none
module cpu6502_load_store_core
  import c6502_pkg::*;
(
  input  wire           clk_i,
  input  wire           rst_ni,
  c6502_in_if.sink      in_i,
  c6502_out_if.source   out_o
);

  // architectural and sequencing state
  logic [15:0] pc_q, pc_d;
  logic [7:0]  a_q, a_d, x_q, x_d, y_q, y_d, sp_q, sp_d, p_q, p_d, op_q, op_d;
  phase_e      ph_q, ph_d;
  logic [15:0] ea_q, ea_d, ba_q, ba_d;
  logic        pcx_q, pcx_d;
  // pending bus access
  logic [15:0] adr_q, adr_d;
  logic        wr_q, wr_d;
  logic [7:0]  wd_q, wd_d;
  // output register
  logic        ov_q;
  logic        bnd_q, bnd_d, ill_q, ill_d;
  logic [3:0]  cyc_q, cyc_d;

  logic        take;
  assign in_i.ready = !ov_q || out_o.ready;
  assign take       = in_i.valid && in_i.ready;

  op_entry_t e_cur, e_new;
  logic [7:0]  d;
  logic [15:0] t, stk;
  assign d     = in_i.read_data;
  assign e_cur = decode(op_q);
  assign e_new = decode(d);
  assign stk   = {StackHi, sp_q};

  function automatic logic [7:0] nz(input logic [7:0] s, input logic [7:0] v);
    logic [7:0] r;
    r = (s & ~(FlagN | FlagZ)) | (v & FlagN);
    if (v == 8'h00) r = r | FlagZ;
    return r;
  endfunction

  always_comb begin
    logic [7:0] sp1;
    pc_d = pc_q; a_d = a_q; x_d = x_q; y_d = y_q; sp_d = sp_q; p_d = p_q; op_d = op_q;
    ph_d = ph_q; ea_d = ea_q; ba_d = ba_q; pcx_d = pcx_q;
    adr_d = adr_q; wr_d = wr_q; wd_d = wd_q;
    bnd_d = 1'b0; cyc_d = 4'd0; ill_d = 1'b0;
    t = 16'h0000; sp1 = 8'h00;
    // operand access once the effective address is known (ea_d)
    unique case (kind_e'(in_i.kind))
      KIND_RST: begin
        a_d = 8'h00; x_d = 8'h00; y_d = 8'h00; sp_d = SpReset; p_d = 8'h00;
        ph_d = P_RST_LO; adr_d = VecReset; wr_d = 1'b0; wd_d = 8'h00;
      end
      KIND_IRQ, KIND_NMI: begin
        // requests are only honoured at an opcode fetch (irq only with I clear), otherwise dropped
        if (ph_q == P_FETCH && (in_i.kind == KIND_NMI || (p_q & FlagI) == 8'h00)) begin
          ba_d = (in_i.kind == KIND_NMI) ? VecNmi : VecIrq;
          ph_d = P_INT_PCH; adr_d = stk; wr_d = 1'b1; wd_d = pc_q[15:8];
        end
      end
      default: begin
        unique case (ph_q)
          P_RST_LO: begin
            ea_d = {8'h00, d}; ph_d = P_RST_HI; adr_d = VecReset + 16'd1; wr_d = 1'b0;
            wd_d = 8'h00;
          end
          P_RST_HI: begin
            pc_d = {d, ea_q[7:0]}; bnd_d = 1'b1; cyc_d = 4'd8;
            ph_d = P_FETCH; adr_d = pc_d; wr_d = 1'b0; wd_d = 8'h00;
          end
          P_FETCH: begin
            op_d = d; pc_d = pc_q + 16'd1; pcx_d = 1'b0; wr_d = 1'b0; wd_d = 8'h00;
            adr_d = pc_d;
            if (!e_new.valid) begin
              bnd_d = 1'b1; cyc_d = 4'd2; ill_d = 1'b1;
            end else if (e_new.mode == M_IMP) begin
              unique case (e_new.oper)
                O_TAX:   begin x_d = a_q;  p_d = nz(p_q, a_q);  end
                O_TAY:   begin y_d = a_q;  p_d = nz(p_q, a_q);  end
                O_TXA:   begin a_d = x_q;  p_d = nz(p_q, x_q);  end
                O_TYA:   begin a_d = y_q;  p_d = nz(p_q, y_q);  end
                O_TSX:   begin x_d = sp_q; p_d = nz(p_q, sp_q); end
                default: sp_d = x_q;
              endcase
              bnd_d = 1'b1; cyc_d = e_new.cyc;
            end else if (e_new.mode == M_STK) begin
              ph_d = P_DATA;
              if (e_new.oper == O_PHA) begin
                adr_d = stk; wr_d = 1'b1; wd_d = a_q;
              end else if (e_new.oper == O_PHP) begin
                adr_d = stk; wr_d = 1'b1; wd_d = p_q;
              end else begin
                sp1 = sp_q + 8'd1; sp_d = sp1; adr_d = {StackHi, sp1};
              end
            end else if (e_new.mode == M_IMM) begin
              ea_d = pc_d; pc_d = pc_q + 16'd2; ph_d = P_DATA; adr_d = ea_d;
            end else begin
              ph_d = P_OPER;
            end
          end
          P_OPER: begin
            pc_d = pc_q + 16'd1; wr_d = 1'b0; wd_d = 8'h00;
            if (!e_cur.valid) begin
              ph_d = P_FETCH; adr_d = pc_d;
            end else begin
              unique case (e_cur.mode)
                M_ZP:  begin ea_d = {8'h00, d}; ph_d = P_DATA; end
                M_ZPX: begin ea_d = {8'h00, d + x_q}; ph_d = P_DATA; end
                M_ZPY: begin ea_d = {8'h00, d + y_q}; ph_d = P_DATA; end
                M_IDX: begin ba_d = {8'h00, d + x_q}; ph_d = P_PTR_LO; end
                M_IDY: begin ba_d = {8'h00, d}; ph_d = P_PTR_LO; end
                default: begin ba_d = {8'h00, d}; ph_d = P_ABS_HI; end
              endcase
              if (ph_d == P_PTR_LO) adr_d = ba_d;
              else if (ph_d == P_ABS_HI) adr_d = pc_d;
              else adr_d = ea_d;
            end
          end
          P_ABS_HI: begin
            pc_d = pc_q + 16'd1; wr_d = 1'b0; wd_d = 8'h00;
            if (!e_cur.valid) begin
              ph_d = P_FETCH; adr_d = pc_d;
            end else begin
              t = {d, ba_q[7:0]};
              if (e_cur.mode == M_ABX) ea_d = t + {8'h00, x_q};
              else if (e_cur.mode == M_ABY) ea_d = t + {8'h00, y_q};
              else ea_d = t;
              pcx_d = (ea_d[15:8] != t[15:8]);
              ph_d = P_DATA; adr_d = ea_d;
            end
          end
          P_PTR_LO: begin
            ea_d = {8'h00, d}; ph_d = P_PTR_HI; wr_d = 1'b0; wd_d = 8'h00;
            adr_d = {8'h00, ba_q[7:0] + 8'd1};
          end
          P_PTR_HI: begin
            wr_d = 1'b0; wd_d = 8'h00;
            if (!e_cur.valid) begin
              ph_d = P_FETCH; adr_d = pc_q;
            end else begin
              t = {d, ea_q[7:0]};
              ea_d = t;
              if (e_cur.mode == M_IDY) begin
                ea_d = t + {8'h00, y_q};
                pcx_d = (ea_d[15:8] != t[15:8]);
              end
              ph_d = P_DATA; adr_d = ea_d;
            end
          end
          P_DATA: begin
            if (e_cur.valid) begin
              unique case (e_cur.oper)
                O_LDA, O_PLA: begin a_d = d; p_d = nz(p_q, d); end
                O_LDX:        begin x_d = d; p_d = nz(p_q, d); end
                O_LDY:        begin y_d = d; p_d = nz(p_q, d); end
                O_PLP:        p_d = d;
                O_PHA, O_PHP: sp_d = sp_q - 8'd1;
                default:      ;
              endcase
              cyc_d = e_cur.cyc;
              if (!(e_cur.oper == O_STA || e_cur.oper == O_STX || e_cur.oper == O_STY)
                  && pcx_q) cyc_d = e_cur.cyc + 4'd1;
            end
            bnd_d = 1'b1; ph_d = P_FETCH; adr_d = pc_q; wr_d = 1'b0; wd_d = 8'h00;
          end
          P_INT_PCH: begin
            sp_d = sp_q - 8'd1; ph_d = P_INT_PCL;
            adr_d = {StackHi, sp_d}; wr_d = 1'b1; wd_d = pc_q[7:0];
          end
          P_INT_PCL: begin
            sp_d = sp_q - 8'd1;
            p_d = p_q | FlagI | FlagU;
            if (ba_q == VecNmi) p_d = p_d & ~FlagB;
            else p_d = p_d | FlagB;
            ph_d = P_INT_P; adr_d = {StackHi, sp_d}; wr_d = 1'b1; wd_d = p_d;
          end
          P_INT_P: begin
            sp_d = sp_q - 8'd1; ph_d = P_INT_VLO; adr_d = ba_q; wr_d = 1'b0; wd_d = 8'h00;
          end
          P_INT_VLO: begin
            ea_d = {8'h00, d}; ph_d = P_INT_VHI; adr_d = ba_q + 16'd1;
            wr_d = 1'b0; wd_d = 8'h00;
          end
          P_INT_VHI: begin
            pc_d = {d, ea_q[7:0]}; bnd_d = 1'b1;
            cyc_d = (ba_q == VecNmi) ? 4'd8 : 4'd7;
            ph_d = P_FETCH; adr_d = pc_d; wr_d = 1'b0; wd_d = 8'h00;
          end
          default: begin
            ph_d = P_FETCH; adr_d = pc_q; wr_d = 1'b0; wd_d = 8'h00;
          end
        endcase
      end
    endcase
    // stores in the operand phase: write data chosen by the instruction
    if (in_i.kind == KIND_DONE && ph_d == P_DATA && ph_q != P_FETCH) begin
      unique case (e_cur.oper)
        O_STA:   begin wr_d = 1'b1; wd_d = a_q; end
        O_STX:   begin wr_d = 1'b1; wd_d = x_q; end
        O_STY:   begin wr_d = 1'b1; wd_d = y_q; end
        default: ;
      endcase
    end
    if (in_i.kind == KIND_DONE && ph_q == P_FETCH && e_new.valid && e_new.mode == M_IMM) begin
      unique case (e_new.oper)
        O_STA:   begin wr_d = 1'b1; wd_d = a_q; end
        O_STX:   begin wr_d = 1'b1; wd_d = x_q; end
        O_STY:   begin wr_d = 1'b1; wd_d = y_q; end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= 16'h0000; a_q <= 8'h00; x_q <= 8'h00; y_q <= 8'h00; sp_q <= SpReset;
      p_q <= 8'h00; op_q <= 8'h00; ph_q <= P_RST_LO; ea_q <= 16'h0000; ba_q <= 16'h0000;
      pcx_q <= 1'b0; adr_q <= VecReset; wr_q <= 1'b0; wd_q <= 8'h00;
      ov_q <= 1'b0; bnd_q <= 1'b0; cyc_q <= 4'd0; ill_q <= 1'b0;
    end else begin
      if (take) begin
        pc_q <= pc_d; a_q <= a_d; x_q <= x_d; y_q <= y_d; sp_q <= sp_d; p_q <= p_d;
        op_q <= op_d; ph_q <= ph_d; ea_q <= ea_d; ba_q <= ba_d; pcx_q <= pcx_d;
        adr_q <= adr_d; wr_q <= wr_d; wd_q <= wd_d;
        bnd_q <= bnd_d; cyc_q <= cyc_d; ill_q <= ill_d;
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // result beat reflects the state just committed
  assign out_o.valid          = ov_q;
  assign out_o.bus_address    = adr_q;
  assign out_o.bus_write      = wr_q;
  assign out_o.write_data     = wr_q ? wd_q : 8'h00;
  assign out_o.at_boundary    = bnd_q;
  assign out_o.cycle_count    = cyc_q;
  assign out_o.illegal_opcode = ill_q;
  assign out_o.reg_a          = a_q;
  assign out_o.reg_x          = x_q;
  assign out_o.reg_y          = y_q;
  assign out_o.reg_sp         = sp_q;
  assign out_o.reg_status     = p_q;
  assign out_o.reg_pc         = pc_q;

endmodule
`default_nettype wire

/* tb/sv/tb_cpu6502_load_store_core.sv */
// tb_cpu6502_load_store_core: self-checking bench for the 6502 load/store core
// depends on c6502_pkg, c6502_if.sv and cpu6502_load_store_core
`default_nettype none
module tb_cpu6502_load_store_core;
  import c6502_pkg::*;

  // one bus-step outcome as the core reports it
  typedef struct {
    logic [15:0] addr;
    logic        wr;
    logic [7:0]  wdata;
    logic        bound;
    logic [3:0]  cyc;
    logic        illegal;
    logic [7:0]  a, x, y, sp, p;
    logic [15:0] pc;
  } bus_step_t;

  typedef struct {
    kind_e      kind;
    logic [7:0] data;
  } bus_beat_t;

  // own decode of the implemented opcodes
  typedef struct {
    logic       ok;
    mode_e      mode;
    oper_e      oper;
    logic [3:0] cyc;
  } insn_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  bit   failed = 1'b0;

  c6502_in_if  in_ch ();
  c6502_out_if out_ch ();

  cpu6502_load_store_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #1 clk_i = ~clk_i;

  // legal opcodes, used to keep random programs mostly well formed
  logic [7:0] legal_ops [41] = '{
    8'hA9, 8'hA5, 8'hB5, 8'hAD, 8'hBD, 8'hB9, 8'hA1, 8'hB1, 8'hA2, 8'hA6, 8'hB6,
    8'hAE, 8'hBE, 8'hA0, 8'hA4, 8'hB4, 8'hAC, 8'hBC, 8'h85, 8'h95, 8'h8D, 8'h9D,
    8'h99, 8'h81, 8'h91, 8'h86, 8'h96, 8'h8E, 8'h84, 8'h94, 8'h8C, 8'hAA, 8'hA8,
    8'h8A, 8'h98, 8'hBA, 8'h9A, 8'h48, 8'h08, 8'h68, 8'h28
  };

  function automatic insn_t decode_insn(input logic [7:0] op);
    insn_t r;
    r = '{1'b1, M_IMP, O_LDA, 4'd2};
    case (op)
      8'hA9: r = '{1'b1, M_IMM, O_LDA, 4'd2};  8'hA5: r = '{1'b1, M_ZP,  O_LDA, 4'd3};
      8'hB5: r = '{1'b1, M_ZPX, O_LDA, 4'd4};  8'hAD: r = '{1'b1, M_ABS, O_LDA, 4'd4};
      8'hBD: r = '{1'b1, M_ABX, O_LDA, 4'd4};  8'hB9: r = '{1'b1, M_ABY, O_LDA, 4'd4};
      8'hA1: r = '{1'b1, M_IDX, O_LDA, 4'd6};  8'hB1: r = '{1'b1, M_IDY, O_LDA, 4'd5};
      8'hA2: r = '{1'b1, M_IMM, O_LDX, 4'd2};  8'hA6: r = '{1'b1, M_ZP,  O_LDX, 4'd3};
      8'hB6: r = '{1'b1, M_ZPY, O_LDX, 4'd4};  8'hAE: r = '{1'b1, M_ABS, O_LDX, 4'd4};
      8'hBE: r = '{1'b1, M_ABY, O_LDX, 4'd4};  8'hA0: r = '{1'b1, M_IMM, O_LDY, 4'd2};
      8'hA4: r = '{1'b1, M_ZP,  O_LDY, 4'd3};  8'hB4: r = '{1'b1, M_ZPX, O_LDY, 4'd4};
      8'hAC: r = '{1'b1, M_ABS, O_LDY, 4'd4};  8'hBC: r = '{1'b1, M_ABX, O_LDY, 4'd4};
      8'h85: r = '{1'b1, M_ZP,  O_STA, 4'd3};  8'h95: r = '{1'b1, M_ZPX, O_STA, 4'd4};
      8'h8D: r = '{1'b1, M_ABS, O_STA, 4'd4};  8'h9D: r = '{1'b1, M_ABX, O_STA, 4'd5};
      8'h99: r = '{1'b1, M_ABY, O_STA, 4'd5};  8'h81: r = '{1'b1, M_IDX, O_STA, 4'd6};
      8'h91: r = '{1'b1, M_IDY, O_STA, 4'd6};  8'h86: r = '{1'b1, M_ZP,  O_STX, 4'd3};
      8'h96: r = '{1'b1, M_ZPY, O_STX, 4'd4};  8'h8E: r = '{1'b1, M_ABS, O_STX, 4'd4};
      8'h84: r = '{1'b1, M_ZP,  O_STY, 4'd3};  8'h94: r = '{1'b1, M_ZPX, O_STY, 4'd4};
      8'h8C: r = '{1'b1, M_ABS, O_STY, 4'd4};  8'hAA: r = '{1'b1, M_IMP, O_TAX, 4'd2};
      8'hA8: r = '{1'b1, M_IMP, O_TAY, 4'd2};  8'h8A: r = '{1'b1, M_IMP, O_TXA, 4'd2};
      8'h98: r = '{1'b1, M_IMP, O_TYA, 4'd2};  8'hBA: r = '{1'b1, M_IMP, O_TSX, 4'd2};
      8'h9A: r = '{1'b1, M_IMP, O_TXS, 4'd2};  8'h48: r = '{1'b1, M_STK, O_PHA, 4'd3};
      8'h08: r = '{1'b1, M_STK, O_PHP, 4'd3};  8'h68: r = '{1'b1, M_STK, O_PLA, 4'd4};
      8'h28: r = '{1'b1, M_STK, O_PLP, 4'd4};
      default: r.ok = 1'b0;
    endcase
    return r;
  endfunction

  // shadow architectural state of the core
  logic [15:0] cpu_pc, cpu_ea, cpu_base;
  logic [7:0]  cpu_a, cpu_x, cpu_y, cpu_sp, cpu_p, cpu_op;
  logic        cpu_cross;
  phase_e      cpu_phase;
  logic [15:0] nxt_addr;
  logic        nxt_wr;
  logic [7:0]  nxt_wdata;

  function automatic void bus_rd(input logic [15:0] ad);
    nxt_addr = ad; nxt_wr = 1'b0; nxt_wdata = 8'h00;
  endfunction

  function automatic void bus_wr(input logic [15:0] ad, input logic [7:0] d);
    nxt_addr = ad; nxt_wr = 1'b1; nxt_wdata = d;
  endfunction

  function automatic void upd_nz(input logic [7:0] v);
    cpu_p = (cpu_p & ~(FlagN | FlagZ)) | (v & FlagN) | ((v == 8'h00) ? FlagZ : 8'h00);
  endfunction

  function automatic void restart_cpu();
    cpu_a = 0; cpu_x = 0; cpu_y = 0; cpu_sp = SpReset; cpu_p = 0;
    cpu_phase = P_RST_LO;
    bus_rd(VecReset);
  endfunction

  // operand access: write for stores, read otherwise
  function automatic void operand_access(input insn_t e);
    cpu_phase = P_DATA;
    case (e.oper)
      O_STA:   bus_wr(cpu_ea, cpu_a);
      O_STX:   bus_wr(cpu_ea, cpu_x);
      O_STY:   bus_wr(cpu_ea, cpu_y);
      default: bus_rd(cpu_ea);
    endcase
  endfunction

  function automatic bus_step_t cpu_step(input kind_e kind, input logic [7:0] d);
    bus_step_t r;
    insn_t     e;
    logic [15:0] t;
    logic [15:0] stk;
    r.bound = 0; r.cyc = 0; r.illegal = 0;
    e = decode_insn(cpu_op);
    stk = {StackHi, cpu_sp};
    if (kind == KIND_RST) begin
      restart_cpu();
    end else if (kind != KIND_DONE) begin
      // interrupts only at an opcode fetch, irq masked by I; otherwise dropped
      if (cpu_phase == P_FETCH && (kind == KIND_NMI || (cpu_p & FlagI) == 0)) begin
        cpu_base = (kind == KIND_NMI) ? VecNmi : VecIrq;
        cpu_phase = P_INT_PCH;
        bus_wr(stk, cpu_pc[15:8]);
      end
    end else begin
      case (cpu_phase)
        P_RST_LO: begin
          cpu_ea = {8'h00, d}; cpu_phase = P_RST_HI; bus_rd(VecReset + 16'd1);
        end
        P_RST_HI: begin
          cpu_pc = {d, cpu_ea[7:0]}; r.bound = 1; r.cyc = 8;
          cpu_phase = P_FETCH; bus_rd(cpu_pc);
        end
        P_FETCH: begin
          cpu_op = d; cpu_pc = cpu_pc + 16'd1; cpu_cross = 0;
          e = decode_insn(d);
          if (!e.ok) begin
            r.bound = 1; r.cyc = 2; r.illegal = 1; bus_rd(cpu_pc);
          end else if (e.mode == M_IMP) begin
            case (e.oper)
              O_TAX:   begin cpu_x = cpu_a;  upd_nz(cpu_x); end
              O_TAY:   begin cpu_y = cpu_a;  upd_nz(cpu_y); end
              O_TXA:   begin cpu_a = cpu_x;  upd_nz(cpu_a); end
              O_TYA:   begin cpu_a = cpu_y;  upd_nz(cpu_a); end
              O_TSX:   begin cpu_x = cpu_sp; upd_nz(cpu_x); end
              default: cpu_sp = cpu_x;
            endcase
            r.bound = 1; r.cyc = e.cyc; bus_rd(cpu_pc);
          end else if (e.mode == M_STK) begin
            cpu_phase = P_DATA;
            if (e.oper == O_PHA) bus_wr(stk, cpu_a);
            else if (e.oper == O_PHP) bus_wr(stk, cpu_p);
            else begin
              cpu_sp = cpu_sp + 8'd1; bus_rd({StackHi, cpu_sp});
            end
          end else if (e.mode == M_IMM) begin
            cpu_ea = cpu_pc; cpu_pc = cpu_pc + 16'd1; operand_access(e);
          end else begin
            cpu_phase = P_OPER; bus_rd(cpu_pc);
          end
        end
        P_OPER: begin
          cpu_pc = cpu_pc + 16'd1;
          if (!e.ok) begin
            cpu_phase = P_FETCH; bus_rd(cpu_pc);
          end else begin
            case (e.mode)
              M_ZP:  begin cpu_ea = {8'h00, d}; operand_access(e); end
              M_ZPX: begin cpu_ea = {8'h00, d + cpu_x}; operand_access(e); end
              M_ZPY: begin cpu_ea = {8'h00, d + cpu_y}; operand_access(e); end
              M_IDX: begin
                cpu_base = {8'h00, d + cpu_x}; cpu_phase = P_PTR_LO; bus_rd(cpu_base);
              end
              M_IDY: begin
                cpu_base = {8'h00, d}; cpu_phase = P_PTR_LO; bus_rd(cpu_base);
              end
              default: begin
                cpu_base = {8'h00, d}; cpu_phase = P_ABS_HI; bus_rd(cpu_pc);
              end
            endcase
          end
        end
        P_ABS_HI: begin
          cpu_pc = cpu_pc + 16'd1;
          if (!e.ok) begin
            cpu_phase = P_FETCH; bus_rd(cpu_pc);
          end else begin
            t = {d, cpu_base[7:0]};
            cpu_ea = t;
            if (e.mode == M_ABX) cpu_ea = t + {8'h00, cpu_x};
            else if (e.mode == M_ABY) cpu_ea = t + {8'h00, cpu_y};
            cpu_cross = (cpu_ea[15:8] != t[15:8]);
            operand_access(e);
          end
        end
        P_PTR_LO: begin
          // second pointer byte wraps within page zero
          cpu_ea = {8'h00, d}; cpu_phase = P_PTR_HI;
          bus_rd({8'h00, cpu_base[7:0] + 8'd1});
        end
        P_PTR_HI: begin
          if (!e.ok) begin
            cpu_phase = P_FETCH; bus_rd(cpu_pc);
          end else begin
            t = {d, cpu_ea[7:0]};
            cpu_ea = t;
            if (e.mode == M_IDY) begin
              cpu_ea = t + {8'h00, cpu_y};
              cpu_cross = (cpu_ea[15:8] != t[15:8]);
            end
            operand_access(e);
          end
        end
        P_DATA: begin
          if (e.ok) begin
            case (e.oper)
              O_LDA, O_PLA: begin cpu_a = d; upd_nz(cpu_a); end
              O_LDX:        begin cpu_x = d; upd_nz(cpu_x); end
              O_LDY:        begin cpu_y = d; upd_nz(cpu_y); end
              O_PLP:        cpu_p = d;
              O_PHA, O_PHP: cpu_sp = cpu_sp - 8'd1;
              default: ;
            endcase
            r.cyc = e.cyc;
            // stores never pay the page cross cycle
            if (!(e.oper inside {O_STA, O_STX, O_STY}) && cpu_cross) r.cyc = r.cyc + 4'd1;
          end
          r.bound = 1; cpu_phase = P_FETCH; bus_rd(cpu_pc);
        end
        P_INT_PCH: begin
          cpu_sp = cpu_sp - 8'd1; cpu_phase = P_INT_PCL;
          bus_wr({StackHi, cpu_sp}, cpu_pc[7:0]);
        end
        P_INT_PCL: begin
          cpu_sp = cpu_sp - 8'd1;
          cpu_p = cpu_p | FlagI | FlagU;
          if (cpu_base == VecNmi) cpu_p = cpu_p & ~FlagB;
          else cpu_p = cpu_p | FlagB;
          cpu_phase = P_INT_P; bus_wr({StackHi, cpu_sp}, cpu_p);
        end
        P_INT_P: begin
          cpu_sp = cpu_sp - 8'd1; cpu_phase = P_INT_VLO; bus_rd(cpu_base);
        end
        P_INT_VLO: begin
          cpu_ea = {8'h00, d}; cpu_phase = P_INT_VHI; bus_rd(cpu_base + 16'd1);
        end
        P_INT_VHI: begin
          cpu_pc = {d, cpu_ea[7:0]}; r.bound = 1;
          r.cyc = (cpu_base == VecNmi) ? 4'd8 : 4'd7;
          cpu_phase = P_FETCH; bus_rd(cpu_pc);
        end
        default: begin
          cpu_phase = P_FETCH; bus_rd(cpu_pc);
        end
      endcase
    end
    r.addr = nxt_addr; r.wr = nxt_wr; r.wdata = nxt_wr ? nxt_wdata : 8'h00;
    r.a = cpu_a; r.x = cpu_x; r.y = cpu_y; r.sp = cpu_sp; r.p = cpu_p; r.pc = cpu_pc;
    return r;
  endfunction

  bus_beat_t beat_q [$];
  bus_step_t step_q [$];

  // predict at queueing time; the core is deterministic so order is all that matters
  task automatic queue_beat(input kind_e k, input logic [7:0] d);
    beat_q.push_back('{k, d});
    step_q.push_back(cpu_step(k, d));
  endtask

  // random beat: mostly well-formed programs, sometimes requests and noise
  task automatic queue_random_beat();
    int unsigned roll;
    logic [7:0]  d;
    roll = $urandom_range(0, 99);
    d = 8'($urandom);
    if (cpu_phase == P_FETCH && $urandom_range(0, 9) != 0)
      d = legal_ops[$urandom_range(0, 40)];
    // operand bytes of 00 or FF now and then so zero page and page edges get hit
    if (cpu_phase != P_FETCH && $urandom_range(0, 3) == 0)
      d = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    if (roll < 4) queue_beat(KIND_IRQ, d);
    else if (roll < 8) queue_beat(KIND_NMI, d);
    else if (roll < 9) queue_beat(KIND_RST, d);
    else queue_beat(KIND_DONE, d);
  endtask

  // driver: offers queued beats with a random gap drawn per beat, no gap in calm phases
  int unsigned send_gap;
  bit          calm;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        if (beat_q.size() != 0 && (calm || $urandom_range(0, 15) == 0)) begin
          // back-to-back beat, valid stays high
          in_ch.valid <= 1'b1;
          in_ch.kind <= beat_q[0].kind;
          in_ch.read_data <= beat_q[0].data;
          void'(beat_q.pop_front());
          send_gap <= 0;
        end else begin
          in_ch.valid <= 1'b0;
          send_gap <= calm ? 0 : $urandom_range(0, 15);
        end
      end else if (!in_ch.valid) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
        end else if (beat_q.size() != 0) begin
          in_ch.valid <= 1'b1;
          in_ch.kind <= beat_q[0].kind;
          in_ch.read_data <= beat_q[0].data;
          void'(beat_q.pop_front());
        end
      end
    end
  end

  // monitor: compares each result beat with the oldest prediction
  int unsigned recv_gap;
  int unsigned hold_left;
  int unsigned results_seen;
  bit          hold_done;

  function automatic void check_field(input string nm, input logic [15:0] e,
                                      input logic [15:0] a);
    if (e !== a) begin
      $display("%0t mismatch %s expected %h actual %h", $realtime, nm, e, a);
      failed = 1'b1;
    end
  endfunction

  always @(posedge clk_i) begin
    bus_step_t e;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen <= results_seen + 1;
        if (step_q.size() == 0) begin
          $display("%0t unexpected result beat addr %h", $realtime, out_ch.bus_address);
          failed = 1'b1;
        end else begin
          e = step_q.pop_front();
          check_field("bus_address", e.addr, out_ch.bus_address);
          check_field("bus_write", 16'(e.wr), 16'(out_ch.bus_write));
          check_field("write_data", 16'(e.wdata), 16'(out_ch.write_data));
          check_field("at_boundary", 16'(e.bound), 16'(out_ch.at_boundary));
          check_field("cycle_count", 16'(e.cyc), 16'(out_ch.cycle_count));
          check_field("illegal_opcode", 16'(e.illegal), 16'(out_ch.illegal_opcode));
          check_field("reg_a", 16'(e.a), 16'(out_ch.reg_a));
          check_field("reg_x", 16'(e.x), 16'(out_ch.reg_x));
          check_field("reg_y", 16'(e.y), 16'(out_ch.reg_y));
          check_field("reg_sp", 16'(e.sp), 16'(out_ch.reg_sp));
          check_field("reg_status", 16'(e.p), 16'(out_ch.reg_status));
          check_field("reg_pc", e.pc, out_ch.reg_pc);
        end
      end
      if (!hold_done && results_seen == 400) begin
        // long hold-off while the driver keeps offering, to back the core up
        hold_done <= 1'b1;
        hold_left <= 300;
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= (hold_left == 1);
      end else if (out_ch.valid && out_ch.ready) begin
        if (calm) begin
          out_ch.ready <= 1'b1;
        end else begin
          recv_gap <= $urandom_range(0, 15);
          out_ch.ready <= 1'b0;
        end
      end else if (!out_ch.ready) begin
        if (recv_gap != 0) recv_gap <= recv_gap - 1;
        else out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_DONE;
    in_ch.read_data = 8'h00;
    out_ch.ready = 1'b0;
    send_gap = 0; calm = 0;
    recv_gap = 0; hold_left = 0; results_seen = 0; hold_done = 0;
    cpu_pc = 0; cpu_op = 0; cpu_ea = 0; cpu_base = 0; cpu_cross = 0;
    restart_cpu();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: vector extremes, immediate, (zp),y, implied, stack and abs,x accesses, special cases
    queue_beat(KIND_DONE, 8'hFF);          // reset vector low
    queue_beat(KIND_DONE, 8'hFF);          // reset vector high, pc wraps on fetch
    queue_beat(KIND_DONE, 8'hA2);          // ldx #
    queue_beat(KIND_IRQ, 8'h00);           // request mid instruction is dropped
    queue_beat(KIND_DONE, 8'hFF);
    queue_beat(KIND_DONE, 8'hB1);          // lda (zp),y
    queue_beat(KIND_DONE, 8'hFF);          // pointer at ff wraps to 00
    queue_beat(KIND_DONE, 8'h80);
    queue_beat(KIND_DONE, 8'h12);
    queue_beat(KIND_DONE, 8'h00);
    queue_beat(KIND_DONE, 8'h02);          // illegal opcode
    queue_beat(KIND_DONE, 8'h9A);          // txs
    queue_beat(KIND_DONE, 8'h08);          // php
    queue_beat(KIND_DONE, 8'h00);
    queue_beat(KIND_DONE, 8'h9D);          // sta abs,x with page cross, no extra cycle
    queue_beat(KIND_DONE, 8'hF0);
    queue_beat(KIND_DONE, 8'h12);
    queue_beat(KIND_DONE, 8'h00);
    queue_beat(KIND_IRQ, 8'h00);           // irq taken at fetch
    repeat (5) queue_beat(KIND_DONE, 8'h40);
    queue_beat(KIND_NMI, 8'hFF);           // nmi with I set still taken
    repeat (5) queue_beat(KIND_DONE, 8'h80);
    queue_beat(KIND_RST, 8'h00);           // restart mid sequence
    repeat (2) wait (beat_q.size() == 0) @(posedge clk_i);

    for (int i = 0; i < 1900; i++) begin
      calm = ((i / 250) % 3 == 2);
      queue_random_beat();
      if (beat_q.size() > 8) wait (beat_q.size() <= 2);
    end

    wait (beat_q.size() == 0 && step_q.size() == 0);
    repeat (20) @(posedge clk_i);
    if (!failed && step_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* cpu6502_load_store_core.f */
design/c6502_pkg.sv
design/c6502_if.sv
design/cpu6502_load_store_core.sv
tb/sv/tb_cpu6502_load_store_core.sv
